// ===== hw/rtl/rqps_pkg.sv =====
// rqps_pkg: types, codes and helpers for the ready queue policy select unit.
// Depends on nothing; used by rqps_slot_ram and ready_queue_policy_select_unit.

package rqps_pkg;

  // Queue geometry
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int unsigned ID_W    = 10;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned RIDX_W  = 4;
  localparam int unsigned OCC_W   = 5;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_READ = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_SJF  = 2'd1,
    POL_PRIO = 2'd2
  } pol_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RDWAIT
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } entry_t;

  typedef struct packed {
    req_type_e          req_type;
    logic [ID_W-1:0]    new_id;
    logic [PRIO_W-1:0]  new_prio;
    logic [BURST_W-1:0] new_burst;
    logic [RIDX_W-1:0]  read_index;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    out_id;
    logic [PRIO_W-1:0]  out_prio;
    logic [BURST_W-1:0] out_burst;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  // Occupancy is reported modulo 2^OCC_W
  function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] n);
    logic [31:0] w;
    w = 32'(n);
    return w[OCC_W-1:0];
  endfunction

  // Shared compare unit: true when cand beats the incumbent under pol.
  // One 16-bit less-than, operands steered by the policy.
  function automatic logic better(input pol_e pol, input entry_t cand, input entry_t inc);
    logic [BURST_W-1:0] lhs;
    logic [BURST_W-1:0] rhs;
    if (pol == POL_SJF) begin
      lhs = cand.burst;
      rhs = inc.burst;
    end else begin
      lhs = BURST_W'(inc.prio);
      rhs = BURST_W'(cand.prio);
    end
    return lhs < rhs;
  endfunction

endpackage

// ===== hw/rtl/rqps_slot_ram.sv =====
// rqps_slot_ram: queue slot store, one write port and one registered read port.
// Depends on rqps_pkg for the entry type and depth.

module rqps_slot_ram
  import rqps_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ready_queue_policy_select_unit.sv =====
// ready_queue_policy_select_unit: bounded ready queue with policy-driven pop.
// Depends on rqps_pkg and rqps_slot_ram.
//
// Usage
//   Request channel: drive req_i and raise start; the transaction is taken
//   at a rising edge with start high and busy low. Push, rejected requests
//   and the unused request code finish in the accepting cycle and busy
//   stays low, so such requests may be issued every cycle.
//   Result channel: rsp_valid_o is high for exactly one cycle with rsp_o.
//   The receiver cannot stall it; it must take the result that cycle.
//   Config channel: cfg_valid_i/cfg_ready_o carry pop_policy (cfg_data_i).
//   Ready is low while busy or start is high; write only when idle.
// Sequencing (start to result strobe), N = occupancy, v = victim position
//   push / full / empty / out of range / unused code : no busy phase
//   read : one slot store read (RDWAIT), then the result
//   pop, FIFO or unused policy : scan of the head slot, then compaction
//   pop, shortest burst or priority: scan of all N slots, then compaction
//     of slots v + 1 to N - 1. Both pops walk the one read port of the
//     slot store, for scan and for compaction.
// Reset: queue empties, pop_policy returns to FIFO, no result pending.
//   Slot contents are not cleared; only slots below the fill level are read.

module ready_queue_policy_select_unit
  import rqps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // request
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  // result
  output logic       rsp_valid_o,
  output rsp_t       rsp_o,
  // configuration
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [1:0]         policy_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;       // next slot to read in scan / shift
  logic [CNT_W-1:0]   end_q, end_d;       // scan length
  logic               pend_q, pend_d;     // read data arrives this cycle
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  entry_t             best_q, best_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  // slot store ports
  logic               we, re;
  logic [IDX_W-1:0]   waddr, raddr;
  entry_t             wdata, rdata;

  logic               full, issue, scan_all;
  pol_e               pol;

  assign pol      = pol_e'(policy_q);
  assign full     = (fill_q == CNT_W'(QUEUE_DEPTH));
  assign scan_all = (pol == POL_SJF) || (pol == POL_PRIO);

  rqps_slot_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      policy_q    <= POL_FIFO;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    end_q      <= end_d;
    pend_idx_q <= pend_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    rsp_q      <= rsp_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    end_d       = end_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    we          = 1'b0;
    waddr       = fill_q[IDX_W-1:0];
    wdata       = '{id: req_i.new_id, prio: req_i.new_prio, burst: req_i.new_burst};
    re          = 1'b0;
    raddr       = cnt_q[IDX_W-1:0];
    issue       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          rsp_d.status    = STAT_OK;
          rsp_d.out_id    = '0;
          rsp_d.out_prio  = '0;
          rsp_d.out_burst = '0;
          rsp_d.occupancy = occ_of(fill_q);
          case (req_i.req_type)
            REQ_PUSH: begin
              rsp_valid_d = 1'b1;
              if (full) begin
                rsp_d.status = STAT_FULL;
              end else begin
                we              = 1'b1;
                fill_d          = fill_q + CNT_W'(1);
                rsp_d.occupancy = occ_of(fill_q + CNT_W'(1));
              end
            end
            REQ_POP: begin
              if (fill_q == '0) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = STAT_EMPTY;
              end else begin
                cnt_d   = '0;
                end_d   = scan_all ? fill_q : CNT_W'(1);
                state_d = ST_SCAN;
              end
            end
            REQ_READ: begin
              if (32'(req_i.read_index) >= 32'(fill_q)) begin
                rsp_valid_d  = 1'b1;
                rsp_d.status = STAT_RANGE;
              end else begin
                re      = 1'b1;
                raddr   = IDX_W'(req_i.read_index);
                state_d = ST_RDWAIT;
              end
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // stream slots through the compare unit, one per cycle
        issue = (cnt_q < end_q);
        if (issue) begin
          re         = 1'b1;
          cnt_d      = cnt_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = cnt_q[IDX_W-1:0];
        end
        if (pend_q) begin
          if ((pend_idx_q == '0) || better(pol, rdata, best_q)) begin
            best_d     = rdata;
            best_idx_d = pend_idx_q;
          end
        end
        if (!issue && !pend_q) begin
          cnt_d   = CNT_W'(best_idx_q) + CNT_W'(1);
          state_d = ST_SHIFT;
        end
      end

      ST_SHIFT: begin
        // close the gap: slot k+1 moves to k, read and write overlapped
        issue = (cnt_q < fill_q);
        if (issue) begin
          re         = 1'b1;
          cnt_d      = cnt_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = cnt_q[IDX_W-1:0];
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = pend_idx_q - IDX_W'(1);
          wdata = rdata;
        end
        if (!issue && !pend_q) begin
          fill_d          = fill_q - CNT_W'(1);
          rsp_valid_d     = 1'b1;
          rsp_d.status    = STAT_OK;
          rsp_d.out_id    = best_q.id;
          rsp_d.out_prio  = best_q.prio;
          rsp_d.out_burst = best_q.burst;
          rsp_d.occupancy = occ_of(fill_q - CNT_W'(1));
          state_d         = ST_IDLE;
        end
      end

      ST_RDWAIT: begin
        rsp_valid_d     = 1'b1;
        rsp_d.status    = STAT_OK;
        rsp_d.out_id    = rdata.id;
        rsp_d.out_prio  = rdata.prio;
        rsp_d.out_burst = rdata.burst;
        rsp_d.occupancy = occ_of(fill_q);
        state_d         = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  // policy is held off while a request is being taken, so a pop scans under one policy
  assign cfg_ready_o = !busy && !start;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // fill level never passes the queue depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(QUEUE_DEPTH))
    else $error("fill level beyond queue depth");

  // fill level moves by one at most
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |->
      ((fill_q == $past(fill_q) + CNT_W'(1)) || (fill_q + CNT_W'(1) == $past(fill_q))))
    else $error("fill level jumped");

  // a result follows either an accepted transaction or the end of a busy phase
  a_rsp_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> ($past(start && !busy) || $fell(busy)))
    else $error("result strobe without a transaction");

  // the selection scan never writes the slot store
  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !we)
    else $error("slot write during scan");

endmodule
